/* rtl/mi_pkg.sv */
// Shared constants and types for the modular inverse block.
`default_nettype none

package mi_pkg;

    // Operand width of the Euclid datapath
    localparam int unsigned WIDTH = 32;
    // Width of the shift count: b << k never exceeds a < 2^WIDTH, so k < WIDTH
    localparam int unsigned K_W = $clog2(WIDTH);

    // Input transaction layout
    localparam int unsigned S_TDATA_W = 2 * WIDTH;
    // Result transaction layout
    localparam int unsigned M_TDATA_W = WIDTH;

    // Sequencer states
    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_LOOP = 8'b0000_0010,
        ST_UP   = 8'b0000_0100,
        ST_DOWN = 8'b0000_1000,
        ST_SWAP = 8'b0001_0000,
        ST_FIN1 = 8'b0010_0000,
        ST_FIN2 = 8'b0100_0000,
        ST_DONE = 8'b1000_0000
    } state_t;

    // Operands handed to the shared arithmetic unit
    typedef struct packed {
        logic [WIDTH:0]   sub_a;
        logic [WIDTH:0]   sub_b;
        logic [WIDTH-1:0] add_a;
        logic [WIDTH-1:0] add_b;
    } alu_in_t;

    // Results returned by the shared arithmetic unit
    typedef struct packed {
        logic [WIDTH:0]   diff;
        logic             borrow;
        logic [WIDTH-1:0] sum;
    } alu_out_t;

endpackage

`default_nettype wire

/* rtl/modular_inverse.sv */
// Modular inverse by extended Euclid on one shared subtract/add unit.
// Sequence: moduli 0 and 1 go straight to DONE; else each Euclid step runs LOOP, UP while
//   doubling the divisor, DOWN while halving it and SWAP, then FIN1, FIN2 (skipped when not coprime), DONE.
// Throughput: one transaction at a time, set by the one subtractor doing each quotient by
//   shift-and-subtract; the next input is taken the cycle after the result is loaded.
// Reset: aresetn synchronous, active low; clears the sequencer and the output valid.
`default_nettype none

module modular_inverse (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            s_tvalid,
    output logic                           s_tready,
    input  wire [mi_pkg::S_TDATA_W-1:0]    s_tdata,   // modulus [31:0], value [63:32]
    output logic                           m_tvalid,
    input  wire                            m_tready,
    output logic [mi_pkg::M_TDATA_W-1:0]   m_tdata,   // inverse [31:0]
    output logic                           m_tuser    // exists [0]
);

    localparam int unsigned W = mi_pkg::WIDTH;

    mi_pkg::state_t state_reg, state_next;

    logic [W-1:0]              a_reg, a_next;      // remainder being reduced
    logic [W-1:0]              b_reg, b_next;      // current divisor
    logic [W-1:0]              bs_reg, bs_next;    // divisor shifted by k
    logic [W-1:0]              mp_reg, mp_next;    // previous coefficient magnitude
    logic [W-1:0]              mc_reg, mc_next;    // current coefficient magnitude
    logic [W-1:0]              ms_reg, ms_next;    // current magnitude shifted by k
    logic [W-1:0]              mod_reg, mod_next;
    logic [W-1:0]              res_reg, res_next;
    logic                      ok_reg, ok_next;
    logic                      par_reg, par_next;  // parity of Euclid step count
    logic [mi_pkg::K_W-1:0]    k_reg, k_next;

    logic                      out_valid_reg, out_valid_next;
    logic [W-1:0]              out_inv_reg, out_inv_next;
    logic                      out_ok_reg, out_ok_next;

    mi_pkg::alu_in_t           alu_in;
    mi_pkg::alu_out_t          alu_out;

    logic                      s_fire;
    logic                      out_free;
    logic [W-1:0]              in_mod;
    logic [W-1:0]              in_val;

    assign in_mod   = s_tdata[W-1:0];
    assign in_val   = s_tdata[2*W-1:W];
    assign s_tready = (state_reg == mi_pkg::ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_inv_reg;
    assign m_tuser  = out_ok_reg;

    mi_alu u_alu (
        .alu_in  (alu_in),
        .alu_out (alu_out)
    );

    // Route operands to the shared unit by state
    always_comb begin
        alu_in = '0;
        unique case (state_reg)
            mi_pkg::ST_UP: begin
                alu_in.sub_a = {1'b0, a_reg};
                alu_in.sub_b = {bs_reg, 1'b0};
            end
            mi_pkg::ST_DOWN: begin
                alu_in.sub_a = {1'b0, a_reg};
                alu_in.sub_b = {1'b0, bs_reg};
                alu_in.add_a = mp_reg;
                alu_in.add_b = ms_reg;
            end
            mi_pkg::ST_FIN1: begin
                alu_in.sub_a = {1'b0, mod_reg};
                alu_in.sub_b = {1'b0, mp_reg};
            end
            mi_pkg::ST_FIN2: begin
                alu_in.sub_a = {1'b0, res_reg};
                alu_in.sub_b = {1'b0, mod_reg};
            end
            default: begin
                alu_in = '0;
            end
        endcase
    end

    // Sequence the Euclid steps
    always_comb begin
        state_next     = state_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        bs_next        = bs_reg;
        mp_next        = mp_reg;
        mc_next        = mc_reg;
        ms_next        = ms_reg;
        mod_next       = mod_reg;
        res_next       = res_reg;
        ok_next        = ok_reg;
        par_next       = par_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_inv_next   = out_inv_reg;
        out_ok_next    = out_ok_reg;

        unique case (state_reg)
            mi_pkg::ST_IDLE: begin
                if (s_fire) begin
                    a_next   = in_mod;
                    b_next   = in_val;
                    mp_next  = '0;
                    mc_next  = {{(W-1){1'b0}}, 1'b1};
                    mod_next = in_mod;
                    par_next = 1'b0;
                    res_next = '0;
                    // Moduli 0 and 1 bypass the loop
                    if (in_mod[W-1:1] == '0) begin
                        ok_next    = in_mod[0];
                        state_next = mi_pkg::ST_DONE;
                    end else begin
                        ok_next    = 1'b0;
                        state_next = mi_pkg::ST_LOOP;
                    end
                end
            end
            mi_pkg::ST_LOOP: begin
                // Start a division step, or finish when the divisor is zero
                if (b_reg == '0) begin
                    state_next = mi_pkg::ST_FIN1;
                end else begin
                    bs_next    = b_reg;
                    ms_next    = mc_reg;
                    k_next     = '0;
                    state_next = mi_pkg::ST_UP;
                end
            end
            mi_pkg::ST_UP: begin
                // Double the divisor while twice it still fits under the remainder
                if (!alu_out.borrow) begin
                    bs_next = {bs_reg[W-2:0], 1'b0};
                    ms_next = {ms_reg[W-2:0], 1'b0};
                    k_next  = k_reg + 1'b1;
                end else begin
                    state_next = mi_pkg::ST_DOWN;
                end
            end
            mi_pkg::ST_DOWN: begin
                // Subtract the shifted divisor where it fits and add the shifted magnitude
                if (!alu_out.borrow) begin
                    a_next  = alu_out.diff[W-1:0];
                    mp_next = alu_out.sum;
                end
                if (k_reg == '0) begin
                    state_next = mi_pkg::ST_SWAP;
                end else begin
                    bs_next = {1'b0, bs_reg[W-1:1]};
                    ms_next = {1'b0, ms_reg[W-1:1]};
                    k_next  = k_reg - 1'b1;
                end
            end
            mi_pkg::ST_SWAP: begin
                // Remainder becomes the new divisor, new magnitude becomes current
                a_next     = b_reg;
                b_next     = a_reg;
                mp_next    = mc_reg;
                mc_next    = mp_reg;
                par_next   = !par_reg;
                state_next = mi_pkg::ST_LOOP;
            end
            mi_pkg::ST_FIN1: begin
                // Check gcd and fold a negative coefficient into range
                if (a_reg != {{(W-1){1'b0}}, 1'b1}) begin
                    res_next   = '0;
                    ok_next    = 1'b0;
                    state_next = mi_pkg::ST_DONE;
                end else begin
                    ok_next = 1'b1;
                    if (!par_reg && (mp_reg != '0)) begin
                        res_next = alu_out.diff[W-1:0];
                    end else begin
                        res_next = mp_reg;
                    end
                    state_next = mi_pkg::ST_FIN2;
                end
            end
            mi_pkg::ST_FIN2: begin
                // Drop one modulus if the result is not below it
                if (!alu_out.borrow) begin
                    res_next = alu_out.diff[W-1:0];
                end
                state_next = mi_pkg::ST_DONE;
            end
            mi_pkg::ST_DONE: begin
                // Hand off to the output register once it is free
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_inv_next   = res_reg;
                    out_ok_next    = ok_reg;
                    state_next     = mi_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mi_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mi_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        a_reg       <= a_next;
        b_reg       <= b_next;
        bs_reg      <= bs_next;
        mp_reg      <= mp_next;
        mc_reg      <= mc_next;
        ms_reg      <= ms_next;
        mod_reg     <= mod_next;
        res_reg     <= res_next;
        ok_reg      <= ok_next;
        par_reg     <= par_next;
        k_reg       <= k_next;
        out_inv_reg <= out_inv_next;
        out_ok_reg  <= out_ok_next;
    end

endmodule

`default_nettype wire

/* rtl/mi_alu.sv */
// Shared subtract/compare and coefficient add unit.
`default_nettype none

module mi_alu (
    input  wire mi_pkg::alu_in_t  alu_in,
    output mi_pkg::alu_out_t      alu_out
);

    logic [mi_pkg::WIDTH+1:0] wide_diff;

    // Subtract with one extra bit to expose the borrow
    assign wide_diff = {1'b0, alu_in.sub_a} - {1'b0, alu_in.sub_b};

    assign alu_out.diff   = wide_diff[mi_pkg::WIDTH:0];
    assign alu_out.borrow = wide_diff[mi_pkg::WIDTH+1];
    // Accumulate the coefficient alongside the remainder
    assign alu_out.sum    = alu_in.add_a + alu_in.add_b;

endmodule

`default_nettype wire
